FILE: hw/rtl/alsq_pkg.sv
// ----------------------------------------------------------------------------
// alsq_pkg: shared definitions for the alarm lamp and buzzer sequencer
// Field widths, command, weigh state and buzzer mode codes, register
// indexes, timing constants and the alarm state test.
// ----------------------------------------------------------------------------
package alsq_pkg;

   localparam int CMD_W        = 2;
   localparam int WS_W         = 3;
   localparam int MODE_W       = 2;
   localparam int TIME_W       = 32;
   localparam int CSR_IDX_W    = 2;
   localparam int REQ_TDATA_W  = 40;  // 36 bits of fields, padded to whole bytes
   localparam int RSP_TDATA_W  = 8;   // 7 bits of fields, padded to whole bytes

   // commands
   localparam logic [CMD_W-1:0] CMD_RESULT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // weigh states
   localparam logic [WS_W-1:0] WS_DISABLED = 3'd0;
   localparam logic [WS_W-1:0] WS_OK       = 3'd1;
   localparam logic [WS_W-1:0] WS_LOW      = 3'd2;
   localparam logic [WS_W-1:0] WS_HIGH     = 3'd3;
   localparam logic [WS_W-1:0] WS_OVERLOAD = 3'd4;
   localparam logic [WS_W-1:0] WS_FAULT    = 3'd5;

   // buzzer modes
   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUAL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALARM = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INT_BUZZER_EN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_BUZZER_EN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAL_BEEP_EN  = 2'd2;

   // timing in milliseconds
   localparam logic [TIME_W-1:0] BEEP_MS  = 32'd100;
   localparam logic [TIME_W-1:0] PHASE_MS = 32'd250;

   // x / 125 for x < 2^31 is (x * PHASE_RECIP) >> PHASE_SHIFT, exact over the range
   localparam logic [31:0] PHASE_RECIP = 32'd2199023256;
   localparam int          PHASE_SHIFT = 38;
   localparam int          QUOT_W      = 25;

   function automatic logic in_alarm_state(input logic [WS_W-1:0] ws);
      in_alarm_state = (ws == WS_HIGH) || (ws == WS_OVERLOAD) || (ws == WS_FAULT);
   endfunction

endpackage

FILE: hw/rtl/alarm_lamp_buzzer_sequencer_top.sv
// ----------------------------------------------------------------------------
// alarm_lamp_buzzer_sequencer_top: stack lamps and buzzers for a checkweigher
// Takes weigh results, timer ticks and all-off commands, and returns one item
// of lamp levels, gated buzzer levels and buzzer mode for each of them.
// ----------------------------------------------------------------------------
// Every accepted item produces exactly one result item. An item is captured in
// an input register, evaluated combinationally against the sequencer state,
// and its result lands in an output register while the state updates, so one
// item per clock is sustained while the result port does not stall; a stalled
// result waits in the output register with the next item held. The longest
// path is the catch-up over missed 250 ms alarm phases: a 31x32 reciprocal
// multiply that divides the elapsed time, then a subtract that realigns the
// phase start. The three enables are written through the csr_ port; write
// them only while no item is in flight.

module alarm_lamp_buzzer_sequencer_top
   import alsq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [2:0] weigh_state, [3] qualified_ok, [35:4] now_ms, [39:36] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] cmd
   input  logic [CMD_W-1:0]       req_tuser,
   // result items
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] green_lamp, [1] yellow_lamp, [2] red_lamp, [3] internal_buzzer,
   // [4] external_buzzer, [6:5] sound mode, [7] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic                   csr_wdata
);

   // configuration registers
   logic int_en_ff, ext_en_ff, qbe_ff;

   // input register
   logic              item_valid_ff;
   logic [CMD_W-1:0]  item_cmd_ff;
   logic [WS_W-1:0]   item_ws_ff;
   logic              item_qok_ff;
   logic [TIME_W-1:0] item_now_ff;

   // sequencer state
   logic [WS_W-1:0]   last_ws_ff,  last_ws_in;
   logic [MODE_W-1:0] mode_ff,     mode_in;
   logic [TIME_W-1:0] phase_ff,    phase_in;
   logic              level_ff,    level_in;

   // result register
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic advance;

   // phase catch-up datapath
   logic [TIME_W-1:0] elapsed;
   logic [30:0]       half;
   logic [62:0]       prod;
   logic [QUOT_W-1:0] quot;
   logic [31:0]       quot_x125;
   logic [31:0]       rem_half;
   logic [7:0]        rem;
   logic [TIME_W-1:0] aligned_start;

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         int_en_ff <= 1'b0;
         ext_en_ff <= 1'b0;
         qbe_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INT_BUZZER_EN: int_en_ff <= csr_wdata;
            CSR_EXT_BUZZER_EN: ext_en_ff <= csr_wdata;
            CSR_QUAL_BEEP_EN:  qbe_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_cmd_ff <= req_tuser;
         item_ws_ff  <= req_tdata[2:0];
         item_qok_ff <= req_tdata[3];
         item_now_ff <= req_tdata[35:4];
      end
   end

   // elapsed / 250 = (elapsed >> 1) / 125; remainder rebuilt from the low bit
   assign elapsed       = item_now_ff - phase_ff;
   assign half          = elapsed[31:1];
   assign prod          = {32'd0, half} * {31'd0, PHASE_RECIP};
   assign quot          = prod[62:PHASE_SHIFT];
   assign quot_x125     = ({7'd0, quot} << 7) - ({7'd0, quot} << 2) + {7'd0, quot};
   assign rem_half      = {1'b0, half} - quot_x125;
   assign rem           = {rem_half[6:0], elapsed[0]};
   // phase_start + phases * 250 is the same as now minus the remainder
   assign aligned_start = item_now_ff - {24'd0, rem};

   always_comb begin
      logic prev_alarm;
      logic now_alarm;
      prev_alarm = in_alarm_state(last_ws_ff);
      now_alarm  = in_alarm_state(item_ws_ff);
      last_ws_in = last_ws_ff;
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      level_in   = level_ff;
      case (item_cmd_ff)
         CMD_RESULT: begin
            last_ws_in = item_ws_ff;
            if (now_alarm) begin
               if (!prev_alarm || mode_ff != MODE_ALARM) begin
                  mode_in  = MODE_ALARM;
                  level_in = 1'b1;
                  phase_in = item_now_ff;
               end
            end else if (item_ws_ff == WS_DISABLED
                         || (mode_ff == MODE_QUAL && !qbe_ff)) begin
               mode_in  = MODE_OFF;
               level_in = 1'b0;
               phase_in = item_now_ff;
            end else if (item_ws_ff == WS_OK && item_qok_ff && qbe_ff) begin
               mode_in  = MODE_QUAL;
               level_in = 1'b1;
               phase_in = item_now_ff;
            end else if (prev_alarm || item_ws_ff != WS_OK) begin
               mode_in  = MODE_OFF;
               level_in = 1'b0;
               phase_in = item_now_ff;
            end
         end
         CMD_TICK: begin
            if (mode_ff == MODE_QUAL) begin
               if (!qbe_ff || elapsed >= BEEP_MS) begin
                  mode_in  = MODE_OFF;
                  level_in = 1'b0;
                  phase_in = item_now_ff;
               end
            end else if (mode_ff == MODE_ALARM) begin
               if (!prev_alarm) begin
                  mode_in  = MODE_OFF;
                  level_in = 1'b0;
                  phase_in = item_now_ff;
               end else if (elapsed >= PHASE_MS) begin
                  // odd number of missed phases flips the level
                  level_in = level_ff ^ quot[0];
                  phase_in = aligned_start;
               end
            end
         end
         CMD_CLEAR: begin
            last_ws_in = WS_DISABLED;
            mode_in    = MODE_OFF;
            phase_in   = '0;
            level_in   = 1'b0;
         end
         default: ;
      endcase

      rsp_data_in    = '0;
      rsp_data_in[0] = (last_ws_in == WS_OK);
      rsp_data_in[1] = (last_ws_in == WS_LOW);
      rsp_data_in[2] = in_alarm_state(last_ws_in);
      rsp_data_in[3] = level_in & int_en_ff;
      rsp_data_in[4] = level_in & ext_en_ff;
      rsp_data_in[6:5] = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ws_ff <= WS_DISABLED;
         mode_ff    <= MODE_OFF;
         phase_ff   <= '0;
         level_ff   <= 1'b0;
      end else if (advance) begin
         last_ws_ff <= last_ws_in;
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         level_ff   <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // at most one lamp lit
   a_one_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(rsp_data_ff[2:0]))
      else $error("more than one lamp lit");

   // buzzer silent whenever its mode is off
   a_off_silent: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_OFF) |-> !level_ff)
      else $error("buzzer level set in off mode");

   // alarm mode only while the stored weigh state is an alarm
   a_alarm_state: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ALARM) |-> in_alarm_state(last_ws_ff))
      else $error("alarm mode without alarm weigh state");

   // an item taken into evaluation shows up as a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result missing after evaluation");

endmodule
